FILE: src/hvn_pkg.sv
package hvn_pkg;

    localparam int unsigned CoordW  = 32;
    localparam int unsigned ClampW  = 8;
    localparam int unsigned CellW   = 4;
    localparam int unsigned CornerW = 5;
    localparam int unsigned NoiseW  = 4;
    localparam int unsigned HashW   = 32;
    localparam int unsigned HeightW = 7;
    localparam int unsigned RowW    = 8;
    localparam int unsigned SumW    = 12;

    localparam logic [HashW-1:0]   MulX       = 32'h9e37_79b9;
    localparam logic [HashW-1:0]   MulZ       = 32'h85eb_ca6b;
    localparam logic [HashW-1:0]   MixA       = 32'h7feb_352d;
    localparam logic [HashW-1:0]   MixB       = 32'h846c_a68b;
    localparam logic [HeightW-1:0] HeightBase = 7'd58;
    localparam logic [SumW-1:0]    BlendRound = 12'd128;
    localparam logic [ClampW-1:0]  ClampMax   = 8'd255;

    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
        logic s5;
    } t_hvn_en;

endpackage

FILE: src/hashed_value_noise_height.sv
// Throughput: one transaction per cycle while i_stall is low; five register
// stages (corner hash input, two multiply rounds, row blend, column blend)
// each hold one item.
// A stage loads whenever it is empty or its successor moves.
// Reset (synchronous, i_rst_n low) clears all stage valid bits and sets the seed to 0.
module hashed_value_noise_height (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_seed_we,
    input  logic [hvn_pkg::HashW-1:0]          i_seed_wdata,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic signed [hvn_pkg::CoordW-1:0]  i_coord_x,
    input  logic signed [hvn_pkg::CoordW-1:0]  i_coord_z,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic [hvn_pkg::HeightW-1:0]        o_height
);

    logic [hvn_pkg::HashW-1:0]   r_seed;
    logic [5:1]                  r_vld;
    logic [6:1]                  ready;
    logic [5:1]                  vld_in;
    hvn_pkg::t_hvn_en            en;
    logic [hvn_pkg::ClampW-1:0]  cx_clamp;
    logic [hvn_pkg::ClampW-1:0]  cz_clamp;
    logic [hvn_pkg::CornerW-1:0] ax0;
    logic [hvn_pkg::CornerW-1:0] ax1;
    logic [hvn_pkg::CornerW-1:0] bz0;
    logic [hvn_pkg::CornerW-1:0] bz1;
    logic [hvn_pkg::CellW-1:0]   r_lx1;
    logic [hvn_pkg::CellW-1:0]   r_lz1;
    logic [hvn_pkg::CellW-1:0]   r_lx2;
    logic [hvn_pkg::CellW-1:0]   r_lz2;
    logic [hvn_pkg::CellW-1:0]   r_lx3;
    logic [hvn_pkg::CellW-1:0]   r_lz3;
    logic [hvn_pkg::NoiseW-1:0]  h00;
    logic [hvn_pkg::NoiseW-1:0]  h10;
    logic [hvn_pkg::NoiseW-1:0]  h01;
    logic [hvn_pkg::NoiseW-1:0]  h11;

    always_comb begin
        priority if (i_coord_x[hvn_pkg::CoordW-1]) begin
            cx_clamp = '0;
        end else if (|i_coord_x[hvn_pkg::CoordW-2:hvn_pkg::ClampW]) begin
            cx_clamp = hvn_pkg::ClampMax;
        end else begin
            cx_clamp = i_coord_x[hvn_pkg::ClampW-1:0];
        end
        priority if (i_coord_z[hvn_pkg::CoordW-1]) begin
            cz_clamp = '0;
        end else if (|i_coord_z[hvn_pkg::CoordW-2:hvn_pkg::ClampW]) begin
            cz_clamp = hvn_pkg::ClampMax;
        end else begin
            cz_clamp = i_coord_z[hvn_pkg::ClampW-1:0];
        end
    end

    assign ax0 = {1'b0, cx_clamp[hvn_pkg::ClampW-1:hvn_pkg::CellW]};
    assign bz0 = {1'b0, cz_clamp[hvn_pkg::ClampW-1:hvn_pkg::CellW]};
    assign ax1 = ax0 + 5'd1;
    assign bz1 = bz0 + 5'd1;

    // advance a stage when empty or when its successor moves
    always_comb begin
        ready[6] = !i_stall;
        for (int k = 5; k >= 1; k--) begin
            ready[k] = !r_vld[k] || ready[k+1];
        end
    end

    assign vld_in = {r_vld[4:1], i_valid};
    assign en = '{s1: ready[1], s2: ready[2], s3: ready[3], s4: ready[4], s5: ready[5]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed <= '0;
            r_vld  <= '0;
        end else begin
            if (i_seed_we) begin
                r_seed <= i_seed_wdata;
            end
            for (int k = 1; k <= 5; k++) begin
                if (ready[k]) begin
                    r_vld[k] <= vld_in[k];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en.s1) begin
            r_lx1 <= cx_clamp[hvn_pkg::CellW-1:0];
            r_lz1 <= cz_clamp[hvn_pkg::CellW-1:0];
        end
        if (en.s2) begin
            r_lx2 <= r_lx1;
            r_lz2 <= r_lz1;
        end
        if (en.s3) begin
            r_lx3 <= r_lx2;
            r_lz3 <= r_lz2;
        end
    end

    hvn_hash u_hash00 (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_seed  (r_seed),
        .i_a     (ax0),
        .i_b     (bz0),
        .o_noise (h00)
    );

    hvn_hash u_hash10 (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_seed  (r_seed),
        .i_a     (ax1),
        .i_b     (bz0),
        .o_noise (h10)
    );

    hvn_hash u_hash01 (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_seed  (r_seed),
        .i_a     (ax0),
        .i_b     (bz1),
        .o_noise (h01)
    );

    hvn_hash u_hash11 (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_seed  (r_seed),
        .i_a     (ax1),
        .i_b     (bz1),
        .o_noise (h11)
    );

    hvn_blend u_blend (
        .i_clk    (i_clk),
        .i_en     (en),
        .i_h00    (h00),
        .i_h10    (h10),
        .i_h01    (h01),
        .i_h11    (h11),
        .i_lx     (r_lx3),
        .i_lz     (r_lz3),
        .o_height (o_height)
    );

    assign o_stall = !ready[1];
    assign o_valid = r_vld[5];

    a_height_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_height >= 7'd58 && o_height <= 7'd73))
        else $error("height out of range");

    a_empty_no_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld == 5'b0) |-> !o_stall)
        else $error("empty pipeline stalls input");

    a_accept_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> r_vld[1])
        else $error("accepted transaction lost at stage 1");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[4] && o_valid && i_stall) |=> (r_vld[4] && o_valid))
        else $error("stalled item dropped inside pipeline");

endmodule

FILE: src/hvn_hash.sv
module hvn_hash (
    input  logic                               i_clk,
    input  hvn_pkg::t_hvn_en                   i_en,
    input  logic [hvn_pkg::HashW-1:0]          i_seed,
    input  logic [hvn_pkg::CornerW-1:0]        i_a,
    input  logic [hvn_pkg::CornerW-1:0]        i_b,
    output logic [hvn_pkg::NoiseW-1:0]         o_noise
);

    logic [hvn_pkg::HashW-1:0] a_ext;
    logic [hvn_pkg::HashW-1:0] b_ext;
    logic [hvn_pkg::HashW-1:0] mix0;
    logic [hvn_pkg::HashW-1:0] mix2;
    logic [hvn_pkg::HashW-1:0] n_v1;
    logic [hvn_pkg::HashW-1:0] n_v2;
    logic [hvn_pkg::HashW-1:0] n_v3;
    logic [hvn_pkg::HashW-1:0] r_v1;
    logic [hvn_pkg::HashW-1:0] r_v2;
    logic [hvn_pkg::HashW-1:0] r_v3;

    assign a_ext = {{(hvn_pkg::HashW-hvn_pkg::CornerW){1'b0}}, i_a};
    assign b_ext = {{(hvn_pkg::HashW-hvn_pkg::CornerW){1'b0}}, i_b};
    assign mix0  = i_seed ^ (a_ext * hvn_pkg::MulX) ^ (b_ext * hvn_pkg::MulZ);
    assign n_v1  = mix0 ^ (mix0 >> 16);
    assign n_v2  = r_v1 * hvn_pkg::MixA;
    assign mix2  = r_v2 ^ (r_v2 >> 15);
    assign n_v3  = mix2 * hvn_pkg::MixB;

    always_ff @(posedge i_clk) begin
        if (i_en.s1) begin
            r_v1 <= n_v1;
        end
        if (i_en.s2) begin
            r_v2 <= n_v2;
        end
        if (i_en.s3) begin
            r_v3 <= n_v3;
        end
    end

    // final xor-shift by 16, low bits only
    assign o_noise = r_v3[hvn_pkg::NoiseW-1:0] ^ r_v3[16 +: hvn_pkg::NoiseW];

endmodule

FILE: src/hvn_blend.sv
module hvn_blend (
    input  logic                               i_clk,
    input  hvn_pkg::t_hvn_en                   i_en,
    input  logic [hvn_pkg::NoiseW-1:0]         i_h00,
    input  logic [hvn_pkg::NoiseW-1:0]         i_h10,
    input  logic [hvn_pkg::NoiseW-1:0]         i_h01,
    input  logic [hvn_pkg::NoiseW-1:0]         i_h11,
    input  logic [hvn_pkg::CellW-1:0]          i_lx,
    input  logic [hvn_pkg::CellW-1:0]          i_lz,
    output logic [hvn_pkg::HeightW-1:0]        o_height
);

    localparam int unsigned RowW = hvn_pkg::RowW;
    localparam int unsigned SumW = hvn_pkg::SumW;

    logic [hvn_pkg::CellW:0]   wx_hi;
    logic [hvn_pkg::CellW:0]   wx_lo;
    logic [hvn_pkg::CellW:0]   wz_hi;
    logic [hvn_pkg::CellW:0]   wz_lo;
    logic [hvn_pkg::RowW-1:0]  n_top;
    logic [hvn_pkg::RowW-1:0]  n_bottom;
    logic [hvn_pkg::RowW-1:0]  r_top;
    logic [hvn_pkg::RowW-1:0]  r_bottom;
    logic [hvn_pkg::CellW-1:0] r_lz;
    logic [hvn_pkg::SumW-1:0]  sum;
    logic [hvn_pkg::HeightW-1:0] n_height;
    logic [hvn_pkg::HeightW-1:0] r_height;

    assign wx_lo = {1'b0, i_lx};
    assign wx_hi = 5'd16 - wx_lo;
    assign n_top    = RowW'(i_h00 * wx_hi) + RowW'(i_h10 * wx_lo);
    assign n_bottom = RowW'(i_h01 * wx_hi) + RowW'(i_h11 * wx_lo);

    assign wz_lo = {1'b0, r_lz};
    assign wz_hi = 5'd16 - wz_lo;
    assign sum = SumW'(r_top * wz_hi) + SumW'(r_bottom * wz_lo) + hvn_pkg::BlendRound;
    assign n_height = hvn_pkg::HeightBase
                    + {{(hvn_pkg::HeightW-4){1'b0}}, sum[SumW-1:SumW-4]};

    always_ff @(posedge i_clk) begin
        if (i_en.s4) begin
            r_top    <= n_top;
            r_bottom <= n_bottom;
            r_lz     <= i_lz;
        end
        if (i_en.s5) begin
            r_height <= n_height;
        end
    end

    assign o_height = r_height;

endmodule
